/* rtl/mahp_pkg.sv */
// Shared types, codes and lookup tables of the MPEG audio header parser.
package mahp_pkg;

  // Layer codes as carried in the header.
  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_III  = 2'd1;
  localparam logic [1:0] LAYER_II   = 2'd2;
  localparam logic [1:0] LAYER_I    = 2'd3;

  // Channel mode codes.
  localparam logic [1:0] MODE_STEREO = 2'd0;
  localparam logic [1:0] MODE_JOINT  = 2'd1;
  localparam logic [1:0] MODE_DUAL   = 2'd2;
  localparam logic [1:0] MODE_MONO   = 2'd3;

  // Table rows.
  localparam logic [1:0] ROW_LOW   = 2'd0;
  localparam logic [1:0] ROW_MPEG1 = 2'd1;
  localparam logic [1:0] ROW_ALT   = 2'd2;

  // Emphasis code that selects the alternate row.
  localparam logic [1:0] EMPH_ALT = 2'd2;

  // Sync pattern: full first byte, top nibble of the second byte.
  localparam logic [7:0] SYNC_B0      = 8'hFF;
  localparam logic [7:0] SYNC_B1_MASK = 8'hF0;

  // Frame size multipliers and the reciprocal scale.
  localparam logic [7:0] SIZE_MUL_L23 = 8'd144;
  localparam logic [7:0] SIZE_MUL_L1  = 8'd12;
  localparam int         RECIP_SHIFT  = 26;

  // Rate limits of MPEG-1 Layer II.
  localparam logic [18:0] PER_CH_MIN = 19'd32000;
  localparam logic [18:0] PER_CH_MAX = 19'd192000;
  localparam logic [18:0] RATE_LOW   = 19'd56000;
  localparam logic [18:0] RATE_MID   = 19'd96000;
  localparam logic [15:0] FS_32K     = 16'd32000;
  localparam logic [15:0] FS_48K     = 16'd48000;

  // Subband bound limits.
  localparam logic [5:0] LIM_8  = 6'd8;
  localparam logic [5:0] LIM_12 = 6'd12;
  localparam logic [5:0] LIM_27 = 6'd27;
  localparam logic [5:0] LIM_30 = 6'd30;
  localparam logic [5:0] LIM_32 = 6'd32;

  // Decoded header fields that travel down the pipeline.
  typedef struct packed {
    logic        ok;
    logic [1:0]  row;
    logic [1:0]  layer;
    logic [18:0] rate;
    logic [15:0] fs;
    logic        crc;
    logic        pad;
    logic [1:0]  mode;
    logic [1:0]  ext;
    logic [5:0]  bound;
    logic [1:0]  chans;
  } hdr_t;

  // Bitrate table, indexed by {row, layer code} and then by the bitrate index.
  localparam logic [18:0] RATE_TAB [16][16] = '{
    '{default: 19'd0},
    '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
      19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
      19'd144000, 19'd160000, 19'd0},
    '{19'd0, 19'd8000, 19'd16000, 19'd24000, 19'd32000, 19'd40000, 19'd48000,
      19'd56000, 19'd64000, 19'd80000, 19'd96000, 19'd112000, 19'd128000,
      19'd144000, 19'd160000, 19'd0},
    '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
      19'd112000, 19'd128000, 19'd144000, 19'd160000, 19'd176000, 19'd192000,
      19'd224000, 19'd256000, 19'd0},
    '{default: 19'd0},
    '{19'd0, 19'd32000, 19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000,
      19'd96000, 19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000,
      19'd256000, 19'd320000, 19'd0},
    '{19'd0, 19'd32000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
      19'd112000, 19'd128000, 19'd160000, 19'd192000, 19'd224000, 19'd256000,
      19'd320000, 19'd384000, 19'd0},
    '{19'd0, 19'd32000, 19'd64000, 19'd96000, 19'd128000, 19'd160000, 19'd192000,
      19'd224000, 19'd256000, 19'd288000, 19'd320000, 19'd352000, 19'd384000,
      19'd416000, 19'd448000, 19'd0},
    '{default: 19'd0},
    '{19'd0, 19'd6000, 19'd8000, 19'd10000, 19'd12000, 19'd16000, 19'd20000,
      19'd24000, 19'd28000, 19'd32000, 19'd40000, 19'd48000, 19'd56000,
      19'd64000, 19'd80000, 19'd0},
    '{19'd0, 19'd6000, 19'd8000, 19'd10000, 19'd12000, 19'd16000, 19'd20000,
      19'd24000, 19'd28000, 19'd32000, 19'd40000, 19'd48000, 19'd56000,
      19'd64000, 19'd80000, 19'd0},
    '{19'd0, 19'd8000, 19'd12000, 19'd16000, 19'd20000, 19'd24000, 19'd32000,
      19'd40000, 19'd48000, 19'd56000, 19'd64000, 19'd80000, 19'd96000,
      19'd112000, 19'd128000, 19'd0},
    '{default: 19'd0},
    '{default: 19'd0},
    '{default: 19'd0},
    '{default: 19'd0}
  };

  // Sample rate table, indexed by {row, sample rate index}.
  localparam logic [15:0] FREQ_TAB [16] = '{
    16'd22050, 16'd24000, 16'd16000, 16'd0,
    16'd44100, 16'd48000, 16'd32000, 16'd0,
    16'd11025, 16'd12000, 16'd8000,  16'd0,
    16'd0,     16'd0,     16'd0,     16'd0
  };

  // Scaled reciprocals floor(2^RECIP_SHIFT / fs), same indexing as FREQ_TAB.
  localparam logic [13:0] RECIP_TAB [16] = '{
    14'd3043, 14'd2796, 14'd4194, 14'd0,
    14'd1521, 14'd1398, 14'd2097, 14'd0,
    14'd6086, 14'd5592, 14'd8388, 14'd0,
    14'd0,    14'd0,    14'd0,    14'd0
  };

endpackage

/* rtl/mahp_in_if.sv */
// Header input channel: valid, ready and one 32-bit header word.
interface mahp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;

  modport source (output valid, output header_word, input ready);
  modport sink   (input valid, input header_word, output ready);
endinterface

/* rtl/mahp_out_if.sv */
// Result channel: valid, ready and the decoded header fields.
interface mahp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [1:0]  version_row;
  logic [1:0]  layer_code;
  logic [18:0] bit_rate;
  logic [15:0] sample_rate;
  logic        crc_present;
  logic        padding;
  logic [1:0]  channel_mode;
  logic [1:0]  stereo_ext;
  logic [5:0]  subband_bound;
  logic [1:0]  channel_count;
  logic [11:0] frame_size;

  modport source (
    output valid, input ready,
    output valid_res, version_row, layer_code, bit_rate, sample_rate, crc_present,
    output padding, channel_mode, stereo_ext, subband_bound, channel_count,
    output frame_size
  );
  modport sink (
    input valid, output ready,
    input valid_res, version_row, layer_code, bit_rate, sample_rate, crc_present,
    input padding, channel_mode, stereo_ext, subband_bound, channel_count,
    input frame_size
  );
endinterface

/* rtl/mpeg_audio_header_parse.sv */
// MPEG audio frame header parser: five-stage pipeline from header word to result.
//
// Usage: each transfer on in_chan carries one 32-bit frame header, first byte in
// bits 31..24. Every header yields exactly one transfer on out_chan, in order.
// valid_res tells whether the header passed the sync, table and rate checks;
// a rejected header comes out with every field, valid_res included, at zero.
// The header passes through five register stages in order: decode and table
// lookup, dividend, reciprocal multiply, back-multiply, and the remainder
// correction that finishes the frame size into the output register. One header
// is taken per cycle as long as the receiver does not stall the pipeline.
// Each stage carries its own valid bit and advances when it is empty or when
// the stage after it moves on, so a stalled receiver backs up the pipeline one
// stage at a time. in_chan.ready drops only when all five stages are full.
// Reset (rst_n low, synchronous) empties every stage; no item is lost or
// repeated under any stall pattern.
module mpeg_audio_header_parse (
  input  logic       clk,
  input  logic       rst_n,
  mahp_in_if.sink    in_chan,
  mahp_out_if.source out_chan
);

  // Stage valid bits and advance enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5_r || out_chan.ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_chan.ready = adv1;

  // Stage 1: sync check, row selection, table lookups and field decode.
  logic [31:0]       w;
  logic [1:0]        row, layer, mode, ext;
  logic [18:0]       rate, per_ch;
  logic [15:0]       fs;
  logic [5:0]        bound_raw, lim;
  logic [1:0]        chans;
  logic              sync_ok, rate_chk;
  mahp_pkg::hdr_t    h1_nxt, h1_r;
  logic [13:0]       recip1_nxt, recip1_r;

  always_comb begin
    w       = in_chan.header_word;
    sync_ok = (w[31:24] == mahp_pkg::SYNC_B0) &&
              ((w[23:16] & mahp_pkg::SYNC_B1_MASK) == mahp_pkg::SYNC_B1_MASK);
    if (!w[19]) begin
      row = mahp_pkg::ROW_LOW;
    end else if (w[1:0] == mahp_pkg::EMPH_ALT) begin
      row = mahp_pkg::ROW_ALT;
    end else begin
      row = mahp_pkg::ROW_MPEG1;
    end
    layer      = w[18:17];
    rate       = mahp_pkg::RATE_TAB[{row, layer}][w[15:12]];
    fs         = mahp_pkg::FREQ_TAB[{row, w[11:10]}];
    recip1_nxt = mahp_pkg::RECIP_TAB[{row, w[11:10]}];
    mode       = w[7:6];
    ext        = (mode == mahp_pkg::MODE_STEREO) ? 2'd0 : w[5:4];
    bound_raw  = (mode == mahp_pkg::MODE_JOINT) ? {1'b0, {1'b0, ext} + 3'd1, 2'b00}
                                                : mahp_pkg::LIM_32;
    chans      = (mode == mahp_pkg::MODE_MONO) ? 2'd1 : 2'd2;
    per_ch     = (mode == mahp_pkg::MODE_MONO) ? rate : {1'b0, rate[18:1]};

    // Layer II bound limits; MPEG-1 Layer II also checks the rate per channel.
    rate_chk = 1'b1;
    lim      = mahp_pkg::LIM_32;
    if (row == mahp_pkg::ROW_MPEG1 && layer == mahp_pkg::LAYER_II) begin
      rate_chk = (per_ch >= mahp_pkg::PER_CH_MIN) && (per_ch <= mahp_pkg::PER_CH_MAX);
      if (rate < mahp_pkg::RATE_LOW) begin
        lim = (fs == mahp_pkg::FS_32K) ? mahp_pkg::LIM_12 : mahp_pkg::LIM_8;
      end else if (rate < mahp_pkg::RATE_MID) begin
        lim = mahp_pkg::LIM_27;
      end else begin
        lim = (fs == mahp_pkg::FS_48K) ? mahp_pkg::LIM_27 : mahp_pkg::LIM_30;
      end
    end else if (layer == mahp_pkg::LAYER_II) begin
      lim = mahp_pkg::LIM_30;
    end

    h1_nxt.ok    = sync_ok && (layer != mahp_pkg::LAYER_NONE) && (rate != 19'd0) &&
                   (fs != 16'd0) && rate_chk;
    h1_nxt.row   = row;
    h1_nxt.layer = layer;
    h1_nxt.rate  = rate;
    h1_nxt.fs    = fs;
    h1_nxt.crc   = ~w[16];
    h1_nxt.pad   = w[9];
    h1_nxt.mode  = mode;
    h1_nxt.ext   = ext;
    h1_nxt.bound = (bound_raw > lim) ? lim : bound_raw;
    h1_nxt.chans = chans;
  end

  // Stage 2: dividend of the frame size, 12 or 144 times the bitrate.
  mahp_pkg::hdr_t h2_r;
  logic [13:0]    recip2_r;
  logic [25:0]    n2_nxt, n2_r;

  assign n2_nxt = (h1_r.layer == mahp_pkg::LAYER_I)
                ? 26'(h1_r.rate) * 26'(mahp_pkg::SIZE_MUL_L1)
                : 26'(h1_r.rate) * 26'(mahp_pkg::SIZE_MUL_L23);

  // Stage 3: quotient estimate by the scaled reciprocal, low by at most one.
  mahp_pkg::hdr_t h3_r;
  logic [25:0]    n3_r;
  logic [39:0]    prod3;
  logic [11:0]    qe3_r;

  assign prod3 = 40'(n2_r) * 40'(recip2_r);

  // Stage 4: multiply the estimate back by the sample rate.
  mahp_pkg::hdr_t h4_r;
  logic [25:0]    n4_r;
  logic [11:0]    qe4_r;
  logic [27:0]    qf4_nxt, qf4_r;

  assign qf4_nxt = 28'(qe3_r) * 28'(h3_r.fs);

  // Stage 5: remainder correction, frame size and zeroing of rejected headers.
  logic [25:0] rem;
  logic [11:0] quo, size;

  always_comb begin
    rem = n4_r - qf4_r[25:0];
    quo = qe4_r + {11'd0, (rem >= 26'(h4_r.fs))};
    if (h4_r.layer == mahp_pkg::LAYER_I) begin
      size = {quo[9:0], 2'b00} + {9'd0, h4_r.pad, 2'b00};
    end else begin
      size = quo + {11'd0, h4_r.pad};
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_chan.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (adv1) begin
      h1_r     <= h1_nxt;
      recip1_r <= recip1_nxt;
    end
    if (adv2) begin
      h2_r     <= h1_r;
      recip2_r <= recip1_r;
      n2_r     <= n2_nxt;
    end
    if (adv3) begin
      h3_r  <= h2_r;
      n3_r  <= n2_r;
      qe3_r <= prod3[mahp_pkg::RECIP_SHIFT +: 12];
    end
    if (adv4) begin
      h4_r  <= h3_r;
      n4_r  <= n3_r;
      qe4_r <= qe3_r;
      qf4_r <= qf4_nxt;
    end
  end

  // Output register; a rejected header leaves all fields at zero.
  logic        ok5_r, crc5_r, pad5_r;
  logic [1:0]  row5_r, layer5_r, mode5_r, ext5_r, chans5_r;
  logic [18:0] rate5_r;
  logic [15:0] fs5_r;
  logic [5:0]  bound5_r;
  logic [11:0] size5_r;

  always_ff @(posedge clk) begin
    if (adv5) begin
      ok5_r    <= h4_r.ok;
      row5_r   <= h4_r.ok ? h4_r.row   : 2'd0;
      layer5_r <= h4_r.ok ? h4_r.layer : 2'd0;
      rate5_r  <= h4_r.ok ? h4_r.rate  : 19'd0;
      fs5_r    <= h4_r.ok ? h4_r.fs    : 16'd0;
      crc5_r   <= h4_r.ok && h4_r.crc;
      pad5_r   <= h4_r.ok && h4_r.pad;
      mode5_r  <= h4_r.ok ? h4_r.mode  : 2'd0;
      ext5_r   <= h4_r.ok ? h4_r.ext   : 2'd0;
      bound5_r <= h4_r.ok ? h4_r.bound : 6'd0;
      chans5_r <= h4_r.ok ? h4_r.chans : 2'd0;
      size5_r  <= h4_r.ok ? size       : 12'd0;
    end
  end

  assign out_chan.valid          = v5_r;
  assign out_chan.valid_res      = ok5_r;
  assign out_chan.version_row    = row5_r;
  assign out_chan.layer_code     = layer5_r;
  assign out_chan.bit_rate       = rate5_r;
  assign out_chan.sample_rate    = fs5_r;
  assign out_chan.crc_present    = crc5_r;
  assign out_chan.padding        = pad5_r;
  assign out_chan.channel_mode   = mode5_r;
  assign out_chan.stereo_ext     = ext5_r;
  assign out_chan.subband_bound  = bound5_r;
  assign out_chan.channel_count  = chans5_r;
  assign out_chan.frame_size     = size5_r;

  // The input is refused only when every stage holds an item.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (v1_r && v2_r && v3_r && v4_r && v5_r && !out_chan.ready))
    else $error("input refused while the pipeline has room");

  // The reciprocal estimate needs at most one correction step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && h4_r.ok) |-> (27'(rem) < {h4_r.fs, 1'b0}))
    else $error("frame size quotient estimate off by more than one");

  // A rejected header carries zeros.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.valid_res) |->
      (out_chan.frame_size == 12'd0 && out_chan.bit_rate == 19'd0 &&
       out_chan.sample_rate == 16'd0 && out_chan.channel_count == 2'd0))
    else $error("rejected header with nonzero fields");

  // An accepted header has table rates and a nonzero frame size.
  a_accept_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.valid_res) |->
      (out_chan.bit_rate != 19'd0 && out_chan.sample_rate != 16'd0 &&
       out_chan.frame_size != 12'd0))
    else $error("accepted header with empty rate or frame size");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the MPEG audio frame header parser.
`timescale 1ns / 100ps

module tb_top;

  localparam int HOLD_CYCLES    = 60;
  localparam int QUIET_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1000;

  // Bitrates in kbit/s, indexed by row, (layer code - 1) and bitrate index.
  localparam int unsigned BITRATE_KBPS [3][3][16] = '{
    '{'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}},
    '{'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}},
    '{'{0, 6, 8, 10, 12, 16, 20, 24, 28, 32, 40, 48, 56, 64, 80, 0},
      '{0, 6, 8, 10, 12, 16, 20, 24, 28, 32, 40, 48, 56, 64, 80, 0},
      '{0, 8, 12, 16, 20, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 0}}
  };

  // Sampling frequencies in Hz, indexed by row and sample rate index.
  localparam int unsigned SAMPLE_HZ [3][4] = '{
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0},
    '{11025, 12000, 8000, 0}
  };

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  version_row;
    logic [1:0]  layer_code;
    logic [18:0] bit_rate;
    logic [15:0] sample_rate;
    logic        crc_present;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  stereo_ext;
    logic [5:0]  subband_bound;
    logic [1:0]  channel_count;
    logic [11:0] frame_size;
  } hdr_result_t;

  // One header to send, with the idling of the phase it belongs to.
  typedef struct {
    logic [31:0] word;
    int          gap_pct;
    int          stall_pct;
    bit          hold_off;
  } hdr_item_t;

  logic clk = 1'b0;
  logic rst_n;

  mahp_in_if  in_chan ();
  mahp_out_if out_chan ();

  mpeg_audio_header_parse dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  hdr_item_t   hdr_pending [$];
  hdr_result_t hdr_expected [$];
  int          total_headers = 0;
  int          sent_cnt      = 0;
  int          err_cnt       = 0;
  int          stall_pct_q   = 0;
  int          hold_token    = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  always #5 clk = ~clk;

  // Decode one header word into the result the block should give.
  function automatic hdr_result_t decode_header(logic [31:0] w);
    hdr_result_t r;
    logic [7:0]  b1, b2, b3;
    logic [1:0]  row, layer, mode, ext;
    int unsigned rate, fs, bound, chans, lim, per, size;
    r  = '0;
    b1 = w[23:16];
    b2 = w[15:8];
    b3 = w[7:0];
    if (w[31:24] != mahp_pkg::SYNC_B0 ||
        (b1 & mahp_pkg::SYNC_B1_MASK) != mahp_pkg::SYNC_B1_MASK) return r;
    row = b1[3] ? mahp_pkg::ROW_MPEG1 : mahp_pkg::ROW_LOW;
    if (row == mahp_pkg::ROW_MPEG1 && b3[1:0] == mahp_pkg::EMPH_ALT) row = mahp_pkg::ROW_ALT;
    layer = b1[2:1];
    if (layer == mahp_pkg::LAYER_NONE) return r;
    rate = BITRATE_KBPS[row][layer - 1][b2[7:4]] * 1000;
    if (rate == 0) return r;
    fs = SAMPLE_HZ[row][b2[3:2]];
    if (fs == 0) return r;

    mode  = b3[7:6];
    ext   = (mode == mahp_pkg::MODE_STEREO) ? 2'd0 : b3[5:4];
    bound = (mode == mahp_pkg::MODE_JOINT) ? (ext + 1) * 4 : 32;
    chans = (mode == mahp_pkg::MODE_MONO) ? 1 : 2;
    lim   = mahp_pkg::LIM_32;

    // MPEG-1 Layer II checks the rate per channel and picks its bound limit.
    if (row == mahp_pkg::ROW_MPEG1 && layer == mahp_pkg::LAYER_II) begin
      per = rate / chans;
      if (per < mahp_pkg::PER_CH_MIN || per > mahp_pkg::PER_CH_MAX) return r;
      if (rate < mahp_pkg::RATE_LOW) begin
        lim = (fs == mahp_pkg::FS_32K) ? mahp_pkg::LIM_12 : mahp_pkg::LIM_8;
      end else if (rate < mahp_pkg::RATE_MID) begin
        lim = mahp_pkg::LIM_27;
      end else begin
        lim = (fs == mahp_pkg::FS_48K) ? mahp_pkg::LIM_27 : mahp_pkg::LIM_30;
      end
    end else if (layer == mahp_pkg::LAYER_II) begin
      lim = mahp_pkg::LIM_30;
    end

    if (layer != mahp_pkg::LAYER_I) begin
      if (bound > lim) bound = lim;
      size = (mahp_pkg::SIZE_MUL_L23 * rate) / fs + b2[1];
    end else begin
      size = ((mahp_pkg::SIZE_MUL_L1 * rate) / fs) * 4 + 4 * b2[1];
    end

    r.valid_res     = 1'b1;
    r.version_row   = row;
    r.layer_code    = layer;
    r.bit_rate      = rate[18:0];
    r.sample_rate   = fs[15:0];
    r.crc_present   = ~b1[0];
    r.padding       = b2[1];
    r.channel_mode  = mode;
    r.stereo_ext    = ext;
    r.subband_bound = bound[5:0];
    r.channel_count = chans[1:0];
    r.frame_size    = size[11:0];
    return r;
  endfunction

  // Mostly headers with a good sync and random content, some noise, some near misses.
  function automatic logic [31:0] random_header();
    logic [31:0] w;
    int          sel;
    sel = $urandom_range(99);
    w   = {12'hFFF, 20'($urandom)};
    if (sel >= 93) w[20 + $urandom_range(11)] = ~w[20 + $urandom_range(11)];
    else if (sel >= 85) w = $urandom;
    return w;
  endfunction

  task automatic queue_header(logic [31:0] w, int gap, int stall, bit hold);
    hdr_item_t it;
    it.word      = w;
    it.gap_pct   = gap;
    it.stall_pct = stall;
    it.hold_off  = hold;
    hdr_pending.push_back(it);
    total_headers++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    logic [31:0] directed [] = '{
      32'hFFFB9000, 32'hFEFB9000, 32'hFFEB9000, 32'hFFF99000, 32'hFFFB0000,
      32'hFFFBF000, 32'hFFFB9C00, 32'hFFFFFFFF, 32'h00000000, 32'hFFFB9002,
      32'hFFFD9002, 32'hFFFE9002, 32'hFFFDE0C0, 32'hFFFD1000, 32'hFFFD18C0,
      32'hFFFD4000, 32'hFFFD4070, 32'hFFFDA400, 32'hFFFDA000, 32'hFFFD30C0,
      32'hFFFE9250, 32'hFFF59030, 32'hFFFDEAB0, 32'hFFFEEAC0, 32'hFFF3E5C1
    };
    int gaps   [4] = '{0, 74, 0, 36};
    int stalls [4] = '{0, 0, 74, 36};
    rst_n = 1'b0;

    foreach (directed[i]) queue_header(directed[i], 0, 0, 1'b0);
    // Four idling phases; a long receiver hold-off lands in the first one.
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        queue_header(random_header(), gaps[p], stalls[p], p == 0 && i == 50);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt != total_headers || hdr_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Driver: offers queued headers and holds each one until its transfer.
  always @(posedge clk) begin : drive_headers
    logic        nxt_valid;
    logic [31:0] nxt_word;
    hdr_item_t   it;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      nxt_valid = in_chan.valid;
      nxt_word  = in_chan.header_word;
      if (in_chan.valid && in_chan.ready) begin
        sent_cnt  <= sent_cnt + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && hdr_pending.size() > 0) begin
        if ($urandom_range(99) >= hdr_pending[0].gap_pct) begin
          it          = hdr_pending.pop_front();
          nxt_valid   = 1'b1;
          nxt_word    = it.word;
          stall_pct_q <= it.stall_pct;
          if (it.hold_off) hold_token <= hold_token + 1;
        end
      end
      in_chan.valid       <= nxt_valid;
      in_chan.header_word <= nxt_word;
    end
  end

  // Monitor: checks each result transfer, predicts each header transfer, drives ready.
  always @(posedge clk) begin : watch_results
    hdr_result_t exp_r;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (hdr_expected.size() == 0) begin
          $error("result transfer with no header pending");
          err_cnt++;
        end else begin
          exp_r = hdr_expected.pop_front();
          check_field("valid_res", 32'(exp_r.valid_res), 32'(out_chan.valid_res));
          check_field("version_row", 32'(exp_r.version_row), 32'(out_chan.version_row));
          check_field("layer_code", 32'(exp_r.layer_code), 32'(out_chan.layer_code));
          check_field("bit_rate", 32'(exp_r.bit_rate), 32'(out_chan.bit_rate));
          check_field("sample_rate", 32'(exp_r.sample_rate), 32'(out_chan.sample_rate));
          check_field("crc_present", 32'(exp_r.crc_present), 32'(out_chan.crc_present));
          check_field("padding", 32'(exp_r.padding), 32'(out_chan.padding));
          check_field("channel_mode", 32'(exp_r.channel_mode),
                      32'(out_chan.channel_mode));
          check_field("stereo_ext", 32'(exp_r.stereo_ext), 32'(out_chan.stereo_ext));
          check_field("subband_bound", 32'(exp_r.subband_bound),
                      32'(out_chan.subband_bound));
          check_field("channel_count", 32'(exp_r.channel_count),
                      32'(out_chan.channel_count));
          check_field("frame_size", 32'(exp_r.frame_size), 32'(out_chan.frame_size));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        hdr_expected.push_back(decode_header(in_chan.header_word));
      end

      // A new hold-off request starts a long stretch with ready low.
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct_q);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
